FILE: hdl/pwl_pkg.sv
package pwl_pkg;

   // Widths of the fixed-point data path and of the item fields.
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned ROWIDX_W = 6;
   localparam int unsigned COL_W    = 3;
   localparam int unsigned RCOUNT_W = 7;
   localparam int unsigned STATUS_W = 2;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_WRITE = 2'd2
   } status_type;

endpackage

FILE: hdl/piecewise_linear_table_interp_unit.sv
// Channel  | Ports                                                   | Handshake
// ---------+---------------------------------------------------------+-------------------------
// request  | req_mode, req_row_index, req_column, req_temperature,   | start high, busy low
//          | req_entry_value                                         |
// response | rsp_status, rsp_result_value                            | rsp_valid strobe, 1 cycle
// control  | csr_row_count (rows in use)                             | csr_valid and csr_ready
//
// A write item is taken while idle; its response strobes on the next cycle.
// A query item reads and checks the last breakpoint, then walks the breakpoint memory one row per
// cycle (at most the rows in use), then either fetches an exact match or fetches both bracketing
// values, runs the 16-step restoring divider and the single multiply.
// Reset clears the sequencer and sets the row count to one; the tables are not cleared.
// The receiver cannot stall: each response is shown for exactly one cycle.
module piecewise_linear_table_interp_unit #(
   parameter int unsigned MAX_ROWS    = 64,
   parameter int unsigned NUM_COLUMNS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic [pwl_pkg::ROWIDX_W-1:0]         req_row_index,
   input  logic [pwl_pkg::COL_W-1:0]            req_column,
   input  logic signed [pwl_pkg::DATA_W-1:0]    req_temperature,
   input  logic signed [pwl_pkg::DATA_W-1:0]    req_entry_value,
   // Response channel.
   output logic                                 rsp_valid,
   output logic [pwl_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [pwl_pkg::DATA_W-1:0]    rsp_result_value,
   // Control register channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pwl_pkg::RCOUNT_W-1:0]         csr_row_count
);

   localparam int unsigned RW    = $clog2(MAX_ROWS);
   localparam int unsigned PDEPTH = MAX_ROWS * NUM_COLUMNS;
   localparam int unsigned PW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
   localparam int unsigned DW    = pwl_pkg::DATA_W;
   localparam int unsigned FW    = pwl_pkg::FRAC_W;
   localparam int unsigned CW    = $clog2(FW);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_LAST,
      ST_CHK_LAST,
      ST_SCAN,
      ST_HIT_A,
      ST_HIT_B,
      ST_BR_A,
      ST_BR_B,
      ST_BR_C,
      ST_DIV,
      ST_MUL,
      ST_FIN
   } state_type;

   state_type                     state_ff;
   logic [pwl_pkg::RCOUNT_W-1:0]  row_count_ff;
   logic [RW-1:0]                 last_ff;
   logic [RW-1:0]                 idx_ff;
   logic [RW-1:0]                 hi_ff;
   logic [pwl_pkg::COL_W-1:0]     col_ff;
   logic                          col_ok_ff;
   logic signed [DW-1:0]          temp_ff;
   logic signed [DW-1:0]          ti1_ff;
   logic signed [DW-1:0]          v0_ff;
   logic signed [DW:0]            dv_ff;
   logic [DW+1:0]                 rem_ff;
   logic [DW:0]                   dti_ff;
   logic [FW-1:0]                 quot_ff;
   logic [CW-1:0]                 cnt_ff;
   logic signed [DW+FW+1:0]       prod_ff;
   logic                          rsp_valid_ff;
   logic [pwl_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic signed [DW-1:0]          rsp_value_ff;

   // Breakpoint and property memories.
   logic [DW-1:0]                 bp_mem [MAX_ROWS];
   logic [DW-1:0]                 pv_mem [PDEPTH];
   logic [DW-1:0]                 bp_rd_ff;
   logic [DW-1:0]                 pv_rd_ff;
   logic [RW-1:0]                 bp_raddr;
   logic [PW-1:0]                 pv_raddr;
   logic [RW-1:0]                 pv_row;

   logic                          accept;
   logic                          wr_row_ok;
   logic                          wr_col_ok;
   logic [RW-1:0]                 wr_row;
   logic [PW-1:0]                 wr_paddr;
   logic [RW-1:0]                 last_in;
   int unsigned                   rows_in_use;

   logic signed [DW-1:0]          bp_rd_s;
   logic signed [DW:0]            dt_wide;
   logic signed [DW:0]            dti_wide;
   logic [DW+1:0]                 rem_shift;
   logic                          rem_ge;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;

   // Write-side address decode.
   assign wr_row_ok = (int'(req_row_index) < MAX_ROWS);
   assign wr_col_ok = (int'(req_column) < NUM_COLUMNS);
   assign wr_row    = RW'(req_row_index);
   assign wr_paddr  = PW'(int'(req_row_index) * NUM_COLUMNS + int'(req_column));

   // Rows in use, clamped to the range one to MAX_ROWS.
   always_comb begin
      rows_in_use = int'(row_count_ff);
      if (rows_in_use == 0) begin
         rows_in_use = 1;
      end
      if (rows_in_use > MAX_ROWS) begin
         rows_in_use = MAX_ROWS;
      end
      last_in = RW'(rows_in_use - 1);
   end

   // Breakpoint read address follows the sequencer.
   always_comb begin
      unique case (state_ff)
         ST_RD_LAST:  bp_raddr = last_ff;
         ST_CHK_LAST: bp_raddr = '0;
         default:     bp_raddr = RW'(idx_ff + 1'b1);
      endcase
   end

   // Property read address: lower row of the bracket, else the selected row.
   assign pv_row   = (state_ff == ST_BR_A) ? RW'(hi_ff - 1'b1) : hi_ff;
   assign pv_raddr = PW'(int'(pv_row) * NUM_COLUMNS + int'(col_ff));

   always_ff @(posedge clock) begin
      if (accept && !req_mode && wr_row_ok) begin
         bp_mem[wr_row] <= req_temperature;
      end
      bp_rd_ff <= bp_mem[bp_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept && !req_mode && wr_row_ok && wr_col_ok) begin
         pv_mem[wr_paddr] <= req_entry_value;
      end
      pv_rd_ff <= pv_mem[pv_raddr];
   end

   // Scan arithmetic: the offsets from the lower breakpoint.
   assign bp_rd_s  = $signed(bp_rd_ff);
   assign dt_wide  = (DW+1)'(temp_ff) - (DW+1)'(ti1_ff);
   assign dti_wide = (DW+1)'(bp_rd_s) - (DW+1)'(ti1_ff);

   // One restoring divide step.
   assign rem_shift = {rem_ff[DW:0], 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, dti_ff});

   // Sequencer, configuration register and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= pwl_pkg::RCOUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            row_count_ff <= csr_row_count;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  temp_ff   <= req_temperature;
                  col_ff    <= req_column;
                  col_ok_ff <= wr_col_ok;
                  last_ff   <= last_in;
                  if (!req_mode) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= pwl_pkg::STATUS_WRITE;
                     rsp_value_ff  <= '0;
                  end else begin
                     state_ff <= ST_RD_LAST;
                  end
               end
            end
            ST_RD_LAST: begin
               state_ff <= ST_CHK_LAST;
            end
            ST_CHK_LAST: begin
               // Column check and upper range check against the last breakpoint.
               if (!col_ok_ff || (temp_ff > bp_rd_s)) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= pwl_pkg::STATUS_RANGE;
                  rsp_value_ff  <= '0;
                  state_ff      <= ST_IDLE;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // One breakpoint per cycle, in row order.
               if (temp_ff < bp_rd_s) begin
                  if ((idx_ff == '0) || (dti_wide <= 0) || (dt_wide < 0)) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= pwl_pkg::STATUS_RANGE;
                     rsp_value_ff  <= '0;
                     state_ff      <= ST_IDLE;
                  end else begin
                     hi_ff    <= idx_ff;
                     rem_ff   <= (DW+2)'(dt_wide);
                     dti_ff   <= dti_wide;
                     state_ff <= ST_BR_A;
                  end
               end else if (temp_ff == bp_rd_s) begin
                  hi_ff    <= idx_ff;
                  state_ff <= ST_HIT_A;
               end else if (idx_ff == last_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= pwl_pkg::STATUS_RANGE;
                  rsp_value_ff  <= '0;
                  state_ff      <= ST_IDLE;
               end else begin
                  ti1_ff <= bp_rd_s;
                  idx_ff <= RW'(idx_ff + 1'b1);
               end
            end
            ST_HIT_A: begin
               state_ff <= ST_HIT_B;
            end
            ST_HIT_B: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= pwl_pkg::STATUS_OK;
               rsp_value_ff  <= $signed(pv_rd_ff);
               state_ff      <= ST_IDLE;
            end
            ST_BR_A: begin
               state_ff <= ST_BR_B;
            end
            ST_BR_B: begin
               v0_ff    <= $signed(pv_rd_ff);
               state_ff <= ST_BR_C;
            end
            ST_BR_C: begin
               dv_ff    <= (DW+1)'($signed(pv_rd_ff)) - (DW+1)'(v0_ff);
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // Fraction bits come out most significant first.
               rem_ff  <= rem_ge ? (rem_shift - {1'b0, dti_ff}) : rem_shift;
               quot_ff <= {quot_ff[FW-2:0], rem_ge};
               cnt_ff  <= CW'(cnt_ff + 1'b1);
               if (cnt_ff == CW'(FW - 1)) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= $signed({1'b0, quot_ff}) * dv_ff;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= pwl_pkg::STATUS_OK;
               rsp_value_ff  <= v0_ff + $signed(prod_ff[DW+FW-1:FW]);
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: tb/sv/tb_piecewise_linear_table_interp_unit.sv
module tb_piecewise_linear_table_interp_unit;

   localparam int TABLE_ROWS  = 64;
   localparam int TABLE_COLS  = 8;
   localparam int CYCLE_LIMIT = 2_000_000;

   // Item kinds carried on req_mode.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Q16.16 values used by the directed items.
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_ZERO    = 32'h0000_0000;
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_ONE     = 32'h0001_0000;
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_HALF    = 32'h0000_8000;
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_MIN     = 32'h8000_0000;
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_MAX     = 32'h7FFF_FFFF;
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_NEG_LSB = 32'hFFFF_FFFF;
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_NEG2    = 32'hFFFE_0000;
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_NEG5    = 32'hFFFB_0000;
   localparam logic [pwl_pkg::DATA_W-1:0] FIX_NEG6    = 32'hFFFA_0000;

   typedef struct packed {
      logic                         mode;
      logic [pwl_pkg::ROWIDX_W-1:0] row;
      logic [pwl_pkg::COL_W-1:0]    col;
      logic [pwl_pkg::DATA_W-1:0]   temp;
      logic [pwl_pkg::DATA_W-1:0]   entry;
   } item_type;

   typedef struct packed {
      pwl_pkg::status_type        st;
      logic [pwl_pkg::DATA_W-1:0] val;
   } answer_type;

   // One row of the directed table: either a row count write or an item.
   typedef struct packed {
      bit                           set_rows;
      logic [pwl_pkg::RCOUNT_W-1:0] rows;
      item_type                     item;
      bit                           typed;
      answer_type                   ans;
   } dir_step_type;

   localparam item_type   NO_ITEM      = '0;
   localparam answer_type NO_ANSWER    = '{pwl_pkg::STATUS_OK, FIX_ZERO};
   localparam answer_type WRITE_DONE   = '{pwl_pkg::STATUS_WRITE, FIX_ZERO};
   localparam answer_type OUT_OF_RANGE = '{pwl_pkg::STATUS_RANGE, FIX_ZERO};
   localparam answer_type ANS_MAX      = '{pwl_pkg::STATUS_OK, FIX_MAX};
   localparam answer_type ANS_MIN      = '{pwl_pkg::STATUS_OK, FIX_MIN};
   localparam answer_type ANS_ZERO     = '{pwl_pkg::STATUS_OK, FIX_ZERO};

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic                               req_mode = 1'b0;
   logic [pwl_pkg::ROWIDX_W-1:0]       req_row_index = '0;
   logic [pwl_pkg::COL_W-1:0]          req_column = '0;
   logic signed [pwl_pkg::DATA_W-1:0]  req_temperature = '0;
   logic signed [pwl_pkg::DATA_W-1:0]  req_entry_value = '0;
   logic                               rsp_valid;
   logic [pwl_pkg::STATUS_W-1:0]       rsp_status;
   logic signed [pwl_pkg::DATA_W-1:0]  rsp_result_value;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [pwl_pkg::RCOUNT_W-1:0]       csr_row_count = 7'd1;

   // Shadow copy of the table and of the row count register.
   logic signed [pwl_pkg::DATA_W-1:0]  breakpoints [TABLE_ROWS];
   bit                                 breakpoint_written [TABLE_ROWS];
   logic signed [pwl_pkg::DATA_W-1:0]  properties [TABLE_ROWS][TABLE_COLS];
   bit                                 property_written [TABLE_ROWS][TABLE_COLS];
   logic [pwl_pkg::RCOUNT_W-1:0]       rows_setting = 7'd1;

   answer_type                expected_answers [$];
   int unsigned               mismatches = 0;
   int unsigned               cycle_count = 0;
   int unsigned               send_idle_pct = 0;

   // Row count settings walked by the random part, extremes included.
   logic [pwl_pkg::RCOUNT_W-1:0] row_settings [18] = '{
      7'd1, 7'd64, 7'd0, 7'd2, 7'd127, 7'd5, 7'd65, 7'd3, 7'd12,
      7'd8, 7'd33, 7'd4, 7'd64, 7'd7, 7'd2, 7'd20, 7'd6, 7'd1
   };

   dir_step_type directed_steps [27] = '{
      // Single row after reset: only an exact hit on the one breakpoint is in range.
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd0, 3'd0, FIX_ONE, FIX_MAX}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd0, FIX_ONE, FIX_ZERO}, 1'b1, ANS_MAX},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd63, 3'd0, FIX_ONE + 32'd1, FIX_MAX}, 1'b1, OUT_OF_RANGE},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd0, FIX_ONE - 32'd1, FIX_ZERO}, 1'b1, OUT_OF_RANGE},
      // Four rows spanning the full temperature range, columns 0 and 7.
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd0, 3'd0, FIX_MIN, FIX_MIN}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd0, 3'd7, FIX_MIN, FIX_MIN}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd1, 3'd0, FIX_ZERO, FIX_MAX}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd1, 3'd7, FIX_ZERO, FIX_MAX}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd2, 3'd0, FIX_ONE, FIX_ZERO}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd2, 3'd7, FIX_ONE, FIX_ONE}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd3, 3'd0, FIX_MAX, FIX_MAX}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd3, 3'd7, FIX_MAX, FIX_MIN}, 1'b1, WRITE_DONE},
      '{1'b1, 7'd4, NO_ITEM, 1'b0, NO_ANSWER},
      // Exact hits on the first and last breakpoints, interpolation, then an exact hit on an inner one.
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd7, FIX_MIN, FIX_ZERO}, 1'b1, ANS_MIN},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd0, FIX_MAX, FIX_ZERO}, 1'b1, ANS_MAX},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd7, FIX_HALF, FIX_ZERO}, 1'b0, NO_ANSWER},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd0, FIX_NEG_LSB, FIX_ZERO}, 1'b0, NO_ANSWER},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd7, FIX_MAX - 32'd1, FIX_ZERO}, 1'b0, NO_ANSWER},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd0, FIX_ONE, FIX_ZERO}, 1'b1, ANS_ZERO},
      // A row count of zero behaves as a single row.
      '{1'b1, 7'd0, NO_ITEM, 1'b0, NO_ANSWER},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd7, FIX_MIN, FIX_ZERO}, 1'b1, ANS_MIN},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd7, FIX_ZERO, FIX_ZERO}, 1'b1, OUT_OF_RANGE},
      // Breakpoints that do not increase: the scan still runs in row order.
      '{1'b1, 7'd3, NO_ITEM, 1'b0, NO_ANSWER},
      '{1'b0, 7'd0, '{MODE_WRITE, 6'd2, 3'd0, FIX_NEG5, FIX_ONE}, 1'b1, WRITE_DONE},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd0, FIX_NEG6, FIX_ZERO}, 1'b0, NO_ANSWER},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd0, FIX_NEG2, FIX_ZERO}, 1'b1, OUT_OF_RANGE},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 3'd0, FIX_NEG5, FIX_ZERO}, 1'b0, NO_ANSWER}
   };

   piecewise_linear_table_interp_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_row_index    (req_row_index),
      .req_column       (req_column),
      .req_temperature  (req_temperature),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_row_count    (csr_row_count)
   );

   always #2 clock = ~clock;

   // Rows in use: zero acts as one and large settings saturate at the table size.
   function automatic int rows_in_use();
      if (rows_setting == 0) return 1;
      if (rows_setting > TABLE_ROWS) return TABLE_ROWS;
      return int'(rows_setting);
   endfunction

   // Predicts the answer to a query from the shadow table. Returns 0 when the scan
   // would read an entry that was never written.
   function automatic bit interpolate_lookup(
         input logic signed [pwl_pkg::DATA_W-1:0] temp,
         input logic [pwl_pkg::COL_W-1:0] col,
         output pwl_pkg::status_type st,
         output logic [pwl_pkg::DATA_W-1:0] val);
      int     n;
      bit     clean;
      longint t, t_lo, t_hi, dt, dti, v_lo, v_hi, f, r;
      n = rows_in_use();
      st = pwl_pkg::STATUS_RANGE;
      val = '0;
      t = temp;
      t_lo = breakpoints[0];
      t_hi = breakpoints[n-1];
      clean = breakpoint_written[0] && breakpoint_written[n-1];
      if (t < t_lo || t > t_hi) return clean;
      if (t == t_lo) begin
         st = pwl_pkg::STATUS_OK;
         val = properties[0][col];
         return clean && property_written[0][col];
      end
      for (int i = 1; i < n; i++) begin
         t_hi = breakpoints[i];
         clean = clean && breakpoint_written[i];
         if (t < t_hi) begin
            clean = clean && property_written[i-1][col] && property_written[i][col];
            dt = t - t_lo;
            dti = t_hi - t_lo;
            if (dti <= 0 || dt < 0) return clean;
            v_lo = properties[i-1][col];
            v_hi = properties[i][col];
            // Q0.16 fraction of the way along the segment, then a flooring shift.
            f = (dt <<< 16) / dti;
            r = v_lo + ((f * (v_hi - v_lo)) >>> 16);
            st = pwl_pkg::STATUS_OK;
            val = r[pwl_pkg::DATA_W-1:0];
            return clean;
         end else if (t == t_hi) begin
            st = pwl_pkg::STATUS_OK;
            val = properties[i][col];
            return clean && property_written[i][col];
         end
         t_lo = t_hi;
      end
      return clean;
   endfunction

   function automatic logic [pwl_pkg::DATA_W-1:0] random_fix();
      case ($urandom_range(0, 7))
         0: return FIX_MIN;
         1: return FIX_MAX;
         2: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
         default: return 32'($urandom);
      endcase
   endfunction

   // Presents one item, waits for it to be taken, then records its expected answer.
   // Start stays high afterwards so that a following item can go back to back.
   task automatic send_item(input item_type it, input bit typed, input answer_type typed_ans);
      answer_type ans;
      // The sender idles in the given share of cycles before it presents the item.
      while ($urandom_range(0, 99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= it.mode;
      req_row_index   <= it.row;
      req_column      <= it.col;
      req_temperature <= it.temp;
      req_entry_value <= it.entry;
      do @(posedge clock); while (busy !== 1'b0);
      // The item has been taken by this edge.
      if (it.mode == MODE_WRITE) begin
         breakpoints[it.row] = it.temp;
         breakpoint_written[it.row] = 1'b1;
         properties[it.row][it.col] = it.entry;
         property_written[it.row][it.col] = 1'b1;
         ans = WRITE_DONE;
      end else begin
         void'(interpolate_lookup(it.temp, it.col, ans.st, ans.val));
      end
      expected_answers.push_back(typed ? typed_ans : ans);
   endtask

   // Holds off new items until every expected answer has come back.
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_row_count(input logic [pwl_pkg::RCOUNT_W-1:0] value);
      csr_valid     <= 1'b1;
      csr_row_count <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid    <= 1'b0;
      rows_setting = value;
   endtask

   // One setting of the row count: fill an increasing table for a few columns,
   // then mostly well-formed queries with some stray writes mixed in.
   task automatic run_phase(input logic [pwl_pkg::RCOUNT_W-1:0] setting);
      int                         n, ncols, base_col, stride, pick, j;
      longint unsigned            step_max, span;
      longint                     t, lo, hi;
      logic [pwl_pkg::COL_W-1:0]  cols [4];
      item_type                   it;
      answer_type                 probe;
      wait_drained();
      write_row_count(setting);
      n = rows_in_use();
      ncols = (n <= 8) ? $urandom_range(1, 4) : (n <= 20) ? $urandom_range(1, 2) : 1;
      base_col = $urandom_range(0, 7);
      stride = 2 * $urandom_range(0, 3) + 1;
      for (int k = 0; k < 4; k++) cols[k] = 3'(base_col + k * stride);

      // Breakpoint spacing: dense, moderate, or spread over the whole range.
      case ($urandom_range(0, 2))
         0: step_max = 4;
         1: step_max = 64'h2_0000;
         default: step_max = 64'hFFFF_FFFF / n;
      endcase
      span = 64'hFFFF_FFFF - step_max * n;
      t = longint'($urandom_range(0, span[31:0])) - 64'sd2147483648;
      for (int r = 0; r < n; r++) begin
         for (int k = 0; k < ncols; k++) begin
            it = '{MODE_WRITE, 6'(r), cols[k], t[31:0], random_fix()};
            send_item(it, 1'b0, NO_ANSWER);
         end
         t += longint'($urandom_range(1, step_max[31:0]));
      end

      repeat (70) begin
         if ($urandom_range(0, 19) == 0) begin
            // Stray write to any row; it may break the ordering of the table.
            it = '{MODE_WRITE, 6'($urandom), 3'($urandom), 32'($urandom), random_fix()};
         end else begin
            do begin
               it.mode = MODE_QUERY;
               it.row = 6'($urandom);
               it.entry = 32'($urandom);
               it.col = ($urandom_range(0, 9) == 0) ? 3'($urandom)
                                                     : cols[$urandom_range(0, ncols - 1)];
               pick = $urandom_range(0, 9);
               if (pick < 5 && n > 1) begin
                  j = $urandom_range(1, n - 1);
                  lo = breakpoints[j-1];
                  hi = breakpoints[j];
                  it.temp = (hi > lo) ? 32'(lo + longint'($urandom_range(0, 32'(hi - lo))))
                                      : lo[31:0];
               end else if (pick < 7) begin
                  it.temp = breakpoints[$urandom_range(0, n - 1)];
               end else if (pick == 7) begin
                  it.temp = breakpoints[0] - 32'sd1;
               end else if (pick == 8) begin
                  it.temp = breakpoints[n-1] + 32'sd1;
               end else begin
                  it.temp = 32'($urandom);
               end
            end while (!interpolate_lookup(it.temp, it.col, probe.st, probe.val));
         end
         if ($urandom_range(0, 49) == 0) wait_drained();
         send_item(it, 1'b0, NO_ANSWER);
      end
   endtask

   // Each response strobe is matched against the oldest expected answer.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_answers.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing expected, status %0d value %h",
                     $time, rsp_status, rsp_result_value);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_status !== want.st) begin
               mismatches++;
               $display("%0t: status expected %0d actual %0d", $time, want.st, rsp_status);
            end
            if (rsp_result_value !== want.val) begin
               mismatches++;
               $display("%0t: result_value expected %h actual %h",
                        $time, want.val, rsp_result_value);
            end
         end
      end
   end

   // Run time limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      dir_step_type d;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items first, starting from the reset row count.
      send_idle_pct = 36;
      foreach (directed_steps[s]) begin
         d = directed_steps[s];
         if (d.set_rows) begin
            wait_drained();
            write_row_count(d.rows);
         end else begin
            send_item(d.item, d.typed, d.ans);
         end
      end

      // Random part: sender idles often, then very often, then never.
      for (int p = 0; p < 18; p++) begin
         send_idle_pct = (p < 6) ? 36 : (p < 12) ? 86 : 0;
         run_phase(row_settings[p]);
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/pwl_pkg.sv
hdl/piecewise_linear_table_interp_unit.sv
tb/sv/tb_piecewise_linear_table_interp_unit.sv
